### rtl/core/quaternion_vector_rotate_top_defines.svh
// ---------------------------------------------------------------------------
// Quaternion vector rotate - assertion macros
// Concurrent assertion forms used by the qvr_finish pipeline module.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define QVR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/qvr_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate - package
// Axis count and cyclic axis helpers for the cross-product terms.
// ---------------------------------------------------------------------------
package qvr_pkg;

  localparam int NUM_AXES = 3;

  // Next axis in the cyclic order x -> y -> z -> x
  function automatic int axis_next(input int i);
    return (i == NUM_AXES - 1) ? 0 : i + 1;
  endfunction

  // Axis after the next one
  function automatic int axis_prev(input int i);
    return (i == 0) ? NUM_AXES - 1 : i - 1;
  endfunction

endpackage

### rtl/core/qvr_in_if.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate - input channel
// Valid/ready channel carrying the vector and the quaternion.
// ---------------------------------------------------------------------------
interface qvr_in_if #(
  parameter int COMP_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] vec_x;
  logic signed [COMP_WIDTH-1:0] vec_y;
  logic signed [COMP_WIDTH-1:0] vec_z;
  logic signed [COMP_WIDTH-1:0] quat_x;
  logic signed [COMP_WIDTH-1:0] quat_y;
  logic signed [COMP_WIDTH-1:0] quat_z;
  logic signed [COMP_WIDTH-1:0] quat_w;

  modport source (
    output valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
    input  ready
  );

  modport sink (
    input  valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
    output ready
  );
endinterface

### rtl/core/qvr_out_if.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate - result channel
// Valid/ready channel carrying the rotated vector and the clip flag.
// ---------------------------------------------------------------------------
interface qvr_out_if #(
  parameter int COMP_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] rot_x;
  logic signed [COMP_WIDTH-1:0] rot_y;
  logic signed [COMP_WIDTH-1:0] rot_z;
  logic                         clipped;

  modport source (
    output valid, rot_x, rot_y, rot_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, clipped,
    output ready
  );
endinterface

### rtl/core/quaternion_vector_rotate_top.sv
// Pipeline: an input passes the qvr_cross stages, then the qvr_finish stages.
// Throughput: one rotation per cycle; each stage holds while its successor is
// full, and bubbles are squeezed out, so an input transfer is taken whenever
// any stage has room (always when the output stage is empty).
// Reset: synchronous, active low; clears the stage valid bits only.
// ---------------------------------------------------------------------------
// Quaternion vector rotate - top level
// Rotates v by a unit quaternion as v + w*t + qv x t with t = 2*(qv x v).
// ---------------------------------------------------------------------------
module quaternion_vector_rotate_top #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input logic clk,
  input logic rst_n,
  qvr_in_if.sink    in_chan,
  qvr_out_if.source out_chan
);

  localparam int TW = 2 * COMP_WIDTH - FRAC_BITS + 2;

  logic signed [COMP_WIDTH-1:0] vec_in  [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat_in [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] vec_mid [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat_mid [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat_w_mid;
  logic signed [TW-1:0]         t_mid   [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] rot     [qvr_pkg::NUM_AXES];
  logic                         mid_valid, mid_ready;

  // gather the channel fields into per-axis arrays
  assign vec_in[0]  = in_chan.vec_x;
  assign vec_in[1]  = in_chan.vec_y;
  assign vec_in[2]  = in_chan.vec_z;
  assign quat_in[0] = in_chan.quat_x;
  assign quat_in[1] = in_chan.quat_y;
  assign quat_in[2] = in_chan.quat_z;

  qvr_cross #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .vec       (vec_in),
    .quat      (quat_in),
    .quat_w    (in_chan.quat_w),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .vec_o     (vec_mid),
    .quat_o    (quat_mid),
    .quat_w_o  (quat_w_mid),
    .t_o       (t_mid)
  );

  qvr_finish #(
    .COMP_WIDTH (COMP_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .vec       (vec_mid),
    .quat      (quat_mid),
    .quat_w    (quat_w_mid),
    .t         (t_mid),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .rot       (rot),
    .clipped   (out_chan.clipped)
  );

  // scatter the result onto the channel
  assign out_chan.rot_x = rot[0];
  assign out_chan.rot_y = rot[1];
  assign out_chan.rot_z = rot[2];

endmodule

### rtl/core/qvr_cross.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate - first cross product
// Two stages: products of qv x v, then round and double to give t.
// ---------------------------------------------------------------------------
module qvr_cross #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COMP_WIDTH-1:0] vec    [qvr_pkg::NUM_AXES],
  input  logic signed [COMP_WIDTH-1:0] quat   [qvr_pkg::NUM_AXES],
  input  logic signed [COMP_WIDTH-1:0] quat_w,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] vec_o  [qvr_pkg::NUM_AXES],
  output logic signed [COMP_WIDTH-1:0] quat_o [qvr_pkg::NUM_AXES],
  output logic signed [COMP_WIDTH-1:0] quat_w_o,
  output logic signed [2*COMP_WIDTH-FRAC_BITS+2-1:0] t_o [qvr_pkg::NUM_AXES]
);

  localparam int PW    = 2 * COMP_WIDTH;
  localparam int DW    = PW + 2;
  localparam int CW_RAW = 2 * COMP_WIDTH - FRAC_BITS + 1;
  localparam int CW    = (CW_RAW < 2) ? 2 : CW_RAW;
  localparam int TW    = 2 * COMP_WIDTH - FRAC_BITS + 2;
  localparam logic signed [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);

  // stage control
  logic v1_r, v2_r;
  logic en1, en2;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // stage 1: the two products of each cross-product component
  logic signed [PW-1:0]         prod_a_r [qvr_pkg::NUM_AXES];
  logic signed [PW-1:0]         prod_b_r [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] vec1_r   [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat1_r  [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat_w1_r;

  // stage 2: t = 2 * round(qv x v)
  logic signed [TW-1:0]         t_r      [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] vec2_r   [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat2_r  [qvr_pkg::NUM_AXES];
  logic signed [COMP_WIDTH-1:0] quat_w2_r;

  for (genvar i = 0; i < qvr_pkg::NUM_AXES; i++) begin : g_axis
    localparam int J = qvr_pkg::axis_next(i);
    localparam int K = qvr_pkg::axis_prev(i);

    logic signed [PW-1:0] prod_a_nxt, prod_b_nxt;
    logic signed [DW-1:0] diff, diff_sh;
    logic signed [TW-1:0] t_nxt;

    assign prod_a_nxt = quat[J] * vec[K];
    assign prod_b_nxt = quat[K] * vec[J];

    // round to nearest, ties upward, then double
    assign diff    = DW'(prod_a_r[i]) - DW'(prod_b_r[i]) + HALF;
    assign diff_sh = diff >>> FRAC_BITS;
    assign t_nxt   = {diff_sh[CW-1:0], 1'b0};

    always_ff @(posedge clk) begin
      if (en1) begin
        prod_a_r[i] <= prod_a_nxt;
        prod_b_r[i] <= prod_b_nxt;
        vec1_r[i]   <= vec[i];
        quat1_r[i]  <= quat[i];
      end
      if (en2) begin
        t_r[i]     <= t_nxt;
        vec2_r[i]  <= vec1_r[i];
        quat2_r[i] <= quat1_r[i];
      end
    end

    assign t_o[i]    = t_r[i];
    assign vec_o[i]  = vec2_r[i];
    assign quat_o[i] = quat2_r[i];
  end

  // carry the scalar part alongside
  always_ff @(posedge clk) begin
    if (en1) begin
      quat_w1_r <= quat_w;
    end
    if (en2) begin
      quat_w2_r <= quat_w1_r;
    end
  end

  assign quat_w_o = quat_w2_r;

endmodule

### rtl/core/qvr_finish.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate - second cross product and sum
// Three stages: split partial products, full products, round/sum/saturate.
// ---------------------------------------------------------------------------
`include "quaternion_vector_rotate_top_defines.svh"

module qvr_finish #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COMP_WIDTH-1:0] vec    [qvr_pkg::NUM_AXES],
  input  logic signed [COMP_WIDTH-1:0] quat   [qvr_pkg::NUM_AXES],
  input  logic signed [COMP_WIDTH-1:0] quat_w,
  input  logic signed [2*COMP_WIDTH-FRAC_BITS+2-1:0] t [qvr_pkg::NUM_AXES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COMP_WIDTH-1:0] rot    [qvr_pkg::NUM_AXES],
  output logic                         clipped
);

  localparam int W   = COMP_WIDTH;
  localparam int TW  = 2 * COMP_WIDTH - FRAC_BITS + 2;
  localparam int TL  = TW / 2;
  localparam int TH  = TW - TL;
  localparam int LPW = W + TL + 1;
  localparam int HPW = W + TH;
  localparam int PW  = W + TW;
  localparam int SW  = PW + 3;
  localparam logic signed [PW+1:0] HALF_D = (PW+2)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0]   HALF_W = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ROT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  ROT_MIN = {1'b1, {(W-1){1'b0}}};

  // partial product against the low half of t, taken as unsigned
  function automatic logic signed [LPW-1:0] mul_lo(
    input logic signed [W-1:0]  a,
    input logic signed [TW-1:0] b
  );
    logic signed [TL:0] b_lo;
    b_lo = $signed({1'b0, b[TL-1:0]});
    return LPW'(a) * LPW'(b_lo);
  endfunction

  // partial product against the signed high half of t
  function automatic logic signed [HPW-1:0] mul_hi(
    input logic signed [W-1:0]  a,
    input logic signed [TW-1:0] b
  );
    logic signed [TH-1:0] b_hi;
    b_hi = $signed(b[TW-1:TL]);
    return HPW'(a) * HPW'(b_hi);
  endfunction

  // recombine the two partials into the exact product
  function automatic logic signed [PW-1:0] join_pp(
    input logic signed [HPW-1:0] hi,
    input logic signed [LPW-1:0] lo
  );
    return (PW'(hi) <<< TL) + PW'(lo);
  endfunction

  // stage control
  logic v3_r, v4_r, v5_r;
  logic en3, en4, en5;

  assign en5       = !v5_r || out_ready;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign in_ready  = en3;
  assign out_valid = v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= in_valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  logic signed [LPW-1:0]  da_lo_r [qvr_pkg::NUM_AXES];
  logic signed [HPW-1:0]  da_hi_r [qvr_pkg::NUM_AXES];
  logic signed [LPW-1:0]  db_lo_r [qvr_pkg::NUM_AXES];
  logic signed [HPW-1:0]  db_hi_r [qvr_pkg::NUM_AXES];
  logic signed [LPW-1:0]  wt_lo_r [qvr_pkg::NUM_AXES];
  logic signed [HPW-1:0]  wt_hi_r [qvr_pkg::NUM_AXES];
  logic signed [W-1:0]    vec3_r  [qvr_pkg::NUM_AXES];
  logic signed [PW:0]     d_raw_r [qvr_pkg::NUM_AXES];
  logic signed [PW-1:0]   wt_raw_r [qvr_pkg::NUM_AXES];
  logic signed [W-1:0]    vec4_r  [qvr_pkg::NUM_AXES];
  logic signed [W-1:0]    rot_r   [qvr_pkg::NUM_AXES];
  logic [qvr_pkg::NUM_AXES-1:0] over;
  logic                   clipped_r;

  for (genvar i = 0; i < qvr_pkg::NUM_AXES; i++) begin : g_axis
    localparam int J = qvr_pkg::axis_next(i);
    localparam int K = qvr_pkg::axis_prev(i);

    logic signed [PW-1:0]   da_full, db_full;
    logic signed [PW:0]     d_raw_nxt;
    logic signed [PW-1:0]   wt_raw_nxt;
    logic signed [PW+1:0]   d_rnd;
    logic signed [PW:0]     wt_rnd;
    logic signed [SW-1:0]   sum;
    logic                   over_hi, over_lo;
    logic signed [W-1:0]    rot_nxt;

    // stage 4: exact products and the cross-product difference
    assign da_full    = join_pp(da_hi_r[i], da_lo_r[i]);
    assign db_full    = join_pp(db_hi_r[i], db_lo_r[i]);
    assign d_raw_nxt  = (PW+1)'(da_full) - (PW+1)'(db_full);
    assign wt_raw_nxt = join_pp(wt_hi_r[i], wt_lo_r[i]);

    // stage 5: round each term, add to v, clamp to the component range
    assign d_rnd   = ((PW+2)'(d_raw_r[i]) + HALF_D) >>> FRAC_BITS;
    assign wt_rnd  = ((PW+1)'(wt_raw_r[i]) + HALF_W) >>> FRAC_BITS;
    assign sum     = SW'(vec4_r[i]) + SW'(wt_rnd) + SW'(d_rnd);
    assign over_hi = sum > SAT_MAX;
    assign over_lo = sum < SAT_MIN;

    always_comb begin
      priority if (over_hi) begin
        rot_nxt = ROT_MAX;
      end else if (over_lo) begin
        rot_nxt = ROT_MIN;
      end else begin
        rot_nxt = sum[W-1:0];
      end
    end

    assign over[i] = over_hi || over_lo;

    always_ff @(posedge clk) begin
      if (en3) begin
        da_lo_r[i] <= mul_lo(quat[J], t[K]);
        da_hi_r[i] <= mul_hi(quat[J], t[K]);
        db_lo_r[i] <= mul_lo(quat[K], t[J]);
        db_hi_r[i] <= mul_hi(quat[K], t[J]);
        wt_lo_r[i] <= mul_lo(quat_w, t[i]);
        wt_hi_r[i] <= mul_hi(quat_w, t[i]);
        vec3_r[i]  <= vec[i];
      end
      if (en4) begin
        d_raw_r[i]  <= d_raw_nxt;
        wt_raw_r[i] <= wt_raw_nxt;
        vec4_r[i]   <= vec3_r[i];
      end
      if (en5) begin
        rot_r[i] <= rot_nxt;
      end
    end

    assign rot[i] = rot_r[i];
  end

  // flag any clamped component
  always_ff @(posedge clk) begin
    if (en5) begin
      clipped_r <= |over;
    end
  end

  assign clipped = clipped_r;

  `QVR_ASSERT_IMPLY(a_clip_at_limit, clk, rst_n, v5_r && clipped_r,
    (rot_r[0] == ROT_MAX) || (rot_r[0] == ROT_MIN) || (rot_r[1] == ROT_MAX) ||
    (rot_r[1] == ROT_MIN) || (rot_r[2] == ROT_MAX) || (rot_r[2] == ROT_MIN),
    "clip flag set with no component at a limit")
  `QVR_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !v5_r, en3,
    "pipeline refuses a transfer with an empty output stage")
  `QVR_ASSERT_NEXT(a_out_from_stage4, clk, rst_n, !v5_r && !v4_r, !v5_r,
    "result appeared without an item in stage 4")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Quaternion vector rotate - testbench
// Streams vector/quaternion pairs through the rotate block under random
// back-pressure and compares every rotated vector and clip flag, in order,
// against hand-worked answers for some directed rows and a behavioural model of the two cross-product rotation.
// ---------------------------------------------------------------------------
module tb;

  localparam int     COMP_WIDTH      = 16;
  localparam int     FRAC_BITS       = 14;
  localparam int     Q_ONE           = 1 << FRAC_BITS;
  localparam int     Q_HALF          = Q_ONE / 2;
  localparam int     Q_DIAG          = 11585;  // cos(45 deg) in Q1.14
  localparam longint ROT_MAX         = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
  localparam longint ROT_MIN         = -ROT_MAX - 1;
  localparam int     N_DIR           = 20;
  localparam int     N_RANDOM        = 1300;
  localparam int     PRESSURE_AT     = 300;
  localparam int     PRESSURE_CYCLES = 80;
  localparam int     DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] vec_x;
    logic signed [COMP_WIDTH-1:0] vec_y;
    logic signed [COMP_WIDTH-1:0] vec_z;
    logic signed [COMP_WIDTH-1:0] quat_x;
    logic signed [COMP_WIDTH-1:0] quat_y;
    logic signed [COMP_WIDTH-1:0] quat_z;
    logic signed [COMP_WIDTH-1:0] quat_w;
  } rot_in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] rot_x;
    logic signed [COMP_WIDTH-1:0] rot_y;
    logic signed [COMP_WIDTH-1:0] rot_z;
    logic                         clipped;
  } rot_out_t;

  // A directed row carries its own answer only where it is obvious by hand
  typedef struct packed {
    rot_in_t  req;
    logic     typed;
    rot_out_t want;
  } dir_row_t;

  typedef enum int {SPAN_MODERATE, SPAN_FULL, SPAN_EDGE} span_t;

  logic clk;
  logic rst_n;

  qvr_in_if  #(.COMP_WIDTH(COMP_WIDTH)) in_chan ();
  qvr_out_if #(.COMP_WIDTH(COMP_WIDTH)) out_chan ();

  quaternion_vector_rotate_top #(
    .COMP_WIDTH(COMP_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  rot_out_t pending_rotations [$];
  int       rot_taken;
  int       mismatches;
  bit       calm;
  bit       rx_holding;
  bit       pressure_done;

  dir_row_t dir_table [N_DIR] = '{
    // identity leaves the vector alone
    '{'{100, -200, 300, 0, 0, 0, Q_ONE}, 1'b1, '{100, -200, 300, 1'b0}},
    '{'{32767, -32768, 0, 0, 0, 0, Q_ONE}, 1'b1, '{32767, -32768, 0, 1'b0}},
    // zero quaternion and negated identity also give the vector back
    '{'{-32768, 32767, -1, 0, 0, 0, 0}, 1'b1, '{-32768, 32767, -1, 1'b0}},
    '{'{1, 2, 3, 0, 0, 0, -Q_ONE}, 1'b1, '{1, 2, 3, 1'b0}},
    // zero vector stays zero whatever the quaternion
    '{'{0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b1, '{0, 0, 0, 1'b0}},
    // half turns about each axis
    '{'{1000, 2000, 3000, 0, 0, Q_ONE, 0}, 1'b1, '{-1000, -2000, 3000, 1'b0}},
    '{'{1000, 2000, 3000, Q_ONE, 0, 0, 0}, 1'b1, '{1000, -2000, -3000, 1'b0}},
    '{'{1000, 2000, 3000, 0, Q_ONE, 0, 0}, 1'b1, '{-1000, 2000, -3000, 1'b0}},
    // half turn of the most negative x overflows
    '{'{-32768, 32767, 0, 0, 0, Q_ONE, 0}, 1'b1, '{32767, -32767, 0, 1'b1}},
    // quarter turns
    '{'{10000, 0, 0, 0, 0, Q_DIAG, Q_DIAG}, 1'b0, '0},
    '{'{0, 10000, -10000, Q_DIAG, 0, 0, Q_DIAG}, 1'b0, '0},
    '{'{-20000, 20000, 20000, 0, -Q_DIAG, 0, Q_DIAG}, 1'b0, '0},
    // extremes of every vector field, quaternion fields at plus or minus one
    '{'{32767, 32767, 32767, Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b0, '0},
    '{'{-32768, -32768, -32768, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE}, 1'b0, '0},
    '{'{32767, -32768, 32767, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE}, 1'b0, '0},
    // rounding ties, positive and negative
    '{'{0, 0, 1, 0, Q_HALF, 0, Q_ONE}, 1'b0, '0},
    '{'{0, 0, -1, 0, Q_HALF, 0, Q_ONE}, 1'b0, '0},
    // quaternion bit patterns at the field extremes and near zero
    '{'{32767, -32768, -1, 32767, -32768, 32767, -32768}, 1'b0, '0},
    '{'{-32768, -32768, -32768, -1, -1, -1, -1}, 1'b0, '0},
    '{'{1, -1, 1, 1, -1, 1, -1}, 1'b0, '0}
  };

  // Round to nearest with ties toward plus infinity, dropping the fraction
  function automatic longint round_frac(input longint x);
    return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Rotated vector and clip flag for one request
  function automatic rot_out_t rotate_vector(input rot_in_t req);
    longint                       v [qvr_pkg::NUM_AXES];
    longint                       q [qvr_pkg::NUM_AXES];
    longint                       t [qvr_pkg::NUM_AXES];
    longint                       w;
    longint                       sum;
    logic signed [COMP_WIDTH-1:0] r [qvr_pkg::NUM_AXES];
    logic                         clip;
    int                           i;
    int                           j;
    int                           k;
    rot_out_t                     res;
    v[0] = $signed(req.vec_x);
    v[1] = $signed(req.vec_y);
    v[2] = $signed(req.vec_z);
    q[0] = $signed(req.quat_x);
    q[1] = $signed(req.quat_y);
    q[2] = $signed(req.quat_z);
    w    = $signed(req.quat_w);
    clip = 1'b0;
    // t = 2 * (qv x v), each component rounded once
    for (i = 0; i < qvr_pkg::NUM_AXES; i++) begin
      j = (i + 1) % qvr_pkg::NUM_AXES;
      k = (i + 2) % qvr_pkg::NUM_AXES;
      t[i] = 2 * round_frac(q[j] * v[k] - q[k] * v[j]);
    end
    // v + w*t + qv x t, summed exactly then saturated
    for (i = 0; i < qvr_pkg::NUM_AXES; i++) begin
      j = (i + 1) % qvr_pkg::NUM_AXES;
      k = (i + 2) % qvr_pkg::NUM_AXES;
      sum = v[i] + round_frac(w * t[i]) + round_frac(q[j] * t[k] - q[k] * t[j]);
      if (sum > ROT_MAX) begin
        sum  = ROT_MAX;
        clip = 1'b1;
      end else if (sum < ROT_MIN) begin
        sum  = ROT_MIN;
        clip = 1'b1;
      end
      r[i] = sum[COMP_WIDTH-1:0];
    end
    res.rot_x   = r[0];
    res.rot_y   = r[1];
    res.rot_z   = r[2];
    res.clipped = clip;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [COMP_WIDTH-1:0] draw_vec_comp(input span_t span);
    logic signed [COMP_WIDTH-1:0] c;
    case (span)
      SPAN_MODERATE: c = COMP_WIDTH'(int'($urandom_range(0, 32000)) - 16000);
      SPAN_FULL:     c = COMP_WIDTH'($urandom());
      default: begin
        case ($urandom_range(0, 6))
          0:       c = -32768;
          1:       c = -32767;
          2:       c = -1;
          3:       c = 0;
          4:       c = 1;
          5:       c = 32766;
          default: c = 32767;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [COMP_WIDTH-1:0] draw_quat_edge();
    logic signed [COMP_WIDTH-1:0] c;
    case ($urandom_range(0, 6))
      0:       c = -Q_ONE;
      1:       c = -Q_ONE + 1;
      2:       c = -1;
      3:       c = 0;
      4:       c = 1;
      5:       c = Q_ONE - 1;
      default: c = Q_ONE;
    endcase
    return c;
  endfunction

  // Offer one request after a random gap (none while calm or while the result
  // side holds), hold it until the transfer, then book the expected rotation
  task automatic offer_rotation(input rot_in_t req, input rot_out_t want);
    int gap;
    gap = (calm || rx_holding) ? 0 : pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.vec_x  <= req.vec_x;
    in_chan.vec_y  <= req.vec_y;
    in_chan.vec_z  <= req.vec_z;
    in_chan.quat_x <= req.quat_x;
    in_chan.quat_y <= req.quat_y;
    in_chan.quat_z <= req.quat_z;
    in_chan.quat_w <= req.quat_w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_rotations.push_back(want);
    rot_taken++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [COMP_WIDTH-1:0] want,
                             input logic signed [COMP_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: random hold-offs, plus one long hold-off to fill the pipe
  initial begin : result_sink
    int   hold;
    logic rdy;
    hold           = 0;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!pressure_done && rot_taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        rx_holding    = 1'b1;
        hold          = PRESSURE_CYCLES;
      end
      if (hold == 0) begin
        rx_holding = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
      if (hold > 0) begin
        rdy = 1'b0;
        hold--;
      end else begin
        rdy = 1'b1;
      end
      out_chan.ready <= rdy;
    end
  end

  // Compare each result transfer with the oldest expected rotation
  always @(posedge clk) begin : result_check
    rot_out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_rotations.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %0d %0d %0d clip %0b", $time,
                 out_chan.rot_x, out_chan.rot_y, out_chan.rot_z, out_chan.clipped);
        mismatches++;
      end else begin
        want = pending_rotations.pop_front();
        check_field("rot_x", want.rot_x, out_chan.rot_x);
        check_field("rot_y", want.rot_y, out_chan.rot_y);
        check_field("rot_z", want.rot_z, out_chan.rot_z);
        check_field("clipped", {{(COMP_WIDTH-1){1'b0}}, want.clipped},
                    {{(COMP_WIDTH-1){1'b0}}, out_chan.clipped});
      end
    end
  end

  // Stimulus: directed table, then random requests in phases
  initial begin : stimulus
    rot_in_t req;
    real     qa [4];
    real     norm;
    int      n;
    int      k;
    int      mode;
    span_t   span;
    rst_n          = 1'b0;
    rot_taken      = 0;
    mismatches     = 0;
    calm           = 1'b0;
    rx_holding     = 1'b0;
    pressure_done  = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.vec_x  = '0;
    in_chan.vec_y  = '0;
    in_chan.vec_z  = '0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    in_chan.quat_w = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < N_DIR; n++) begin
      offer_rotation(dir_table[n].req,
                     dir_table[n].typed ? dir_table[n].want : rotate_vector(dir_table[n].req));
    end

    for (n = 0; n < N_RANDOM; n++) begin
      // some phases run with no idling on either side
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        // unit quaternion from a random direction in four dimensions
        norm = 0.0;
        for (k = 0; k < 4; k++) begin
          qa[k] = real'(int'($urandom_range(0, 2000)) - 1000);
          norm  = norm + qa[k] * qa[k];
        end
        if (norm < 1.0) begin
          qa[3] = 1.0;
          norm  = 1.0;
        end
        norm       = $sqrt(norm);
        req.quat_x = COMP_WIDTH'($rtoi(qa[0] / norm * Q_ONE));
        req.quat_y = COMP_WIDTH'($rtoi(qa[1] / norm * Q_ONE));
        req.quat_z = COMP_WIDTH'($rtoi(qa[2] / norm * Q_ONE));
        req.quat_w = COMP_WIDTH'($rtoi(qa[3] / norm * Q_ONE));
        span       = (mode < 50) ? SPAN_MODERATE : SPAN_FULL;
      end else if (mode < 85) begin
        // any quaternion with components from -1 to +1 in Q1.14, not normalised
        req.quat_x = COMP_WIDTH'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        req.quat_y = COMP_WIDTH'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        req.quat_z = COMP_WIDTH'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        req.quat_w = COMP_WIDTH'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
        span       = SPAN_FULL;
      end else if (mode < 95) begin
        req.quat_x = draw_quat_edge();
        req.quat_y = draw_quat_edge();
        req.quat_z = draw_quat_edge();
        req.quat_w = draw_quat_edge();
        span       = SPAN_EDGE;
      end else begin
        // raw bit patterns, well outside the unit range
        req.quat_x = COMP_WIDTH'($urandom());
        req.quat_y = COMP_WIDTH'($urandom());
        req.quat_z = COMP_WIDTH'($urandom());
        req.quat_w = COMP_WIDTH'($urandom());
        span       = SPAN_FULL;
      end
      req.vec_x = draw_vec_comp(span);
      req.vec_y = draw_vec_comp(span);
      req.vec_z = draw_vec_comp(span);
      offer_rotation(req, rotate_vector(req));
    end
    in_chan.valid <= 1'b0;

    // drain, then allow the pipe to show any stray result
    while (pending_rotations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
